// ----- design/bm25s_pkg.sv -----
// bm25s_pkg: shared types, constants and the log2 fraction table for the bm25 scorer
// no dependencies; used by bm25s_muldiv, bm25s_lognorm and bm25_document_scorer

package bm25s_pkg;

  localparam int SCORE_W         = 28;
  localparam int SCORE_FRAC_BITS = 16;
  localparam int TERM_SHIFT      = 52 - SCORE_FRAC_BITS;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  localparam int LOG_FRAC  = 28;
  localparam int LOG_DEPTH = 256;
  localparam int LOG_LB    = $clog2(LOG_DEPTH);
  localparam logic [27:0] LN2_Q28 = 28'd186065279;

  localparam int DIV_W = 64;
  localparam int CNT_W = 6;

  localparam logic [9:0] K_RESET = 10'd307;
  localparam logic [8:0] B_RESET = 9'd192;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_DOCS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LEN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_K      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_WEIGHT = 8'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RATIO,
    ST_LNI,
    ST_LDI,
    ST_IDF,
    ST_NRM,
    ST_DEN,
    ST_NUM,
    ST_FAC,
    ST_TRM,
    ST_ACC
  } state_t;

  // request to the serial multiply/divide unit
  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [CNT_W-1:0] steps;
    logic [DIV_W-1:0] a;  // multiplicand, or starting remainder
    logic [DIV_W-1:0] b;  // multiplier, or divisor
    logic [DIV_W-1:0] c;  // low dividend bits, msb aligned
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] prod;
    logic [DIV_W-1:0] quo;
  } md_rsp_t;

  typedef logic [LOG_FRAC:0] log_tab_t [0:LOG_DEPTH];

  // log2(1 + i/depth) in q28 by repeated squaring in q30
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] z;
    logic [27:0] r;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      z = ((64'(LOG_DEPTH) + 64'(i)) << 30) / LOG_DEPTH;
      r = '0;
      for (int s = 0; s < LOG_FRAC; s++) begin
        z = (z * z) >> 30;
        r = {r[26:0], 1'b0};
        if (z >= (64'd1 << 31)) begin
          z = z >> 1;
          r[0] = 1'b1;
        end
      end
      t[i] = {1'b0, r};
    end
    t[LOG_DEPTH] = (LOG_FRAC+1)'(1) << LOG_FRAC;
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// ----- design/bm25s_muldiv.sv -----
// bm25s_muldiv: bit-serial shift-add multiplier and restoring divider, one step per cycle
// depends on bm25s_pkg

module bm25s_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  bm25s_pkg::md_req_t req,
  output bm25s_pkg::md_rsp_t rsp
);
  import bm25s_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic             done;
  logic             div;
  logic [DIV_W-1:0] r1, r2, r3, q;
  logic [DIV_W-1:0] rem_sh, rem_next;
  logic             ge;

  always_comb begin
    rem_sh   = {r1[DIV_W-2:0], r2[DIV_W-1]};
    ge       = rem_sh >= r3;
    rem_next = ge ? rem_sh - r3 : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (req.start) begin
        cnt <= req.steps;
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div <= req.is_div;
      r1  <= req.is_div ? req.a : '0;
      r2  <= req.is_div ? req.c : req.a;
      r3  <= req.b;
      q   <= '0;
    end else if (cnt != '0) begin
      if (div) begin
        r1 <= rem_next;
        r2 <= r2 << 1;
        q  <= {q[DIV_W-2:0], ge};
      end else begin
        if (r3[0]) begin
          r1 <= r1 + r2;
        end
        r2 <= r2 << 1;
        r3 <= r3 >> 1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = r1;
  assign rsp.quo  = q;

endmodule

// ----- design/bm25s_lognorm.sv -----
// bm25s_lognorm: normalizes a nonzero word one bit per cycle for the log2 lookup
// depends on bm25s_pkg

module bm25s_lognorm (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x,
  output logic [31:0] mant,
  output logic [4:0]  expo,
  output logic        done
);
  import bm25s_pkg::*;

  logic [4:0] shifts;

  always_ff @(posedge clk) begin
    if (rst) begin
      shifts <= '0;
    end else if (start) begin
      shifts <= '0;
    end else if (!mant[31]) begin
      shifts <= shifts + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mant <= x;
    end else if (!mant[31]) begin
      mant <= mant << 1;
    end
  end

  assign expo = 5'd31 - shifts;
  assign done = mant[31];

endmodule

// ----- design/bm25_document_scorer.sv -----
// bm25_document_scorer: okapi bm25 term scoring with a running per-document sum
// depends on bm25s_pkg, bm25s_muldiv, bm25s_lognorm
//
// usage
//   s_axis carries one query term per word: tdata holds term_frequency,
//   document_frequency and document_length, tlast marks the document's last term.
//   cfg writes set total_documents, average_length, k1 and b; cfg_ready is always
//   high and writes belong to idle periods between documents.
//   m_axis gives one word per document, on its last term: tdata holds the q12.16
//   score, tuser the flag that the sum saturated.
// timing
//   a term is taken, then the bit-serial multiply/divide unit runs nine jobs in
//   turn (one 44-step and one 27-step division, seven multiplies of 9 to 28
//   steps); a term that adds zero skips all nine jobs.
//   s_axis_tready is high only between terms. the score sits in an output
//   register; a stalled receiver holds the block only when the next document's
//   last term is ready to hand over.
// reset
//   sync reset clears the sum, the flag, the output word and restores the
//   register defaults (k1 307, b 192, n and average length zero).

module bm25_document_scorer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bm25s_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bm25s_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // term_frequency, document_frequency, document_length
  input  logic        s_axis_tlast,   // last_term
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // score
  output logic        m_axis_tuser    // saturated
);
  import bm25s_pkg::*;

  logic [23:0] total_docs;
  logic [27:0] avg_len;
  logic [9:0]  sat_k;
  logic [8:0]  len_w;

  state_t state, state_next;
  logic   issued;

  logic [15:0] tf;
  logic [23:0] dfc;
  logic [19:0] dl;
  logic        last_q;
  logic [32:0] ln_q, ld_q, idf;
  logic [43:0] ratio;
  logic [44:0] norm;
  logic [47:0] den;
  logic [34:0] num;
  logic [26:0] factor;
  logic [SCORE_W-1:0] term_q, score_sum;
  logic               ovf;

  logic [SCORE_W-1:0] out_score;
  logic               out_sat;
  logic               out_valid;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic        norm_start;
  logic [31:0] ln_x, ld_x, ln_m, ld_m, sel_m;
  logic [4:0]  ln_e, ld_e, sel_e;
  logic        ln_done, ld_done;

  logic [LOG_LB-1:0]     tab_idx;
  logic [31-LOG_LB:0]    tab_w;
  logic [LOG_FRAC:0]     tab_lo, tab_hi, tab_d;
  logic [32:0]           log_val;
  logic [32:0]           diff;
  logic [8:0]            bc;
  logic [DIV_W-1:0]      term_w;
  logic [SCORE_W:0]      sum_w;
  logic                  hit;
  logic                  zero_term;
  logic                  in_take, out_free;

  bm25s_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  bm25s_lognorm u_log_n (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .x     (ln_x),
    .mant  (ln_m),
    .expo  (ln_e),
    .done  (ln_done)
  );

  bm25s_lognorm u_log_d (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .x     (ld_x),
    .mant  (ld_m),
    .expo  (ld_e),
    .done  (ld_done)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(32-SCORE_W){1'b0}}, out_score};
  assign m_axis_tuser  = out_sat;

  // log inputs: 2n+2 and 2df+1
  assign ln_x = {7'd0, total_docs, 1'b0} + 32'd2;
  assign ld_x = {7'd0, dfc, 1'b1};

  always_comb begin
    sel_m   = (state == ST_LDI) ? ld_m : ln_m;
    sel_e   = (state == ST_LDI) ? ld_e : ln_e;
    tab_idx = sel_m[30 -: LOG_LB];
    tab_w   = {sel_m[30-LOG_LB:0], 1'b0};
    tab_lo  = LOG_TAB[{1'b0, tab_idx}];
    tab_hi  = LOG_TAB[{1'b0, tab_idx} + (LOG_LB+1)'(1)];
    if (tab_hi < tab_lo) begin
      tab_hi = tab_lo;
    end
    tab_d   = tab_hi - tab_lo;
    log_val = 33'({sel_e, {LOG_FRAC{1'b0}}}) + 33'(tab_lo)
            + 33'(md_rsp.prod >> (32 - LOG_LB));
    diff    = (ln_q > ld_q) ? ln_q - ld_q : '0;
    bc      = (len_w > 9'd256) ? 9'd256 : len_w;
    term_w  = md_rsp.prod >> TERM_SHIFT;
    sum_w   = {1'b0, score_sum} + {1'b0, term_q};
    hit     = sum_w >= (SCORE_W+1)'(SCORE_MAX);
    zero_term = (tf == '0) || (dfc == '0) || (avg_len == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    md_req        = '0;
    norm_start    = 1'b0;
    md_req.start  = !issued;
    unique case (state)
      ST_IDLE: begin
        md_req.start = 1'b0;
        if (in_take) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        md_req.start = 1'b0;
        state_next   = zero_term ? ST_ACC : ST_RATIO;
      end
      ST_RATIO: begin
        norm_start    = !issued;
        md_req.is_div = 1'b1;
        md_req.steps  = CNT_W'(44);
        md_req.b      = DIV_W'(avg_len);
        md_req.c      = {dl, 44'd0};
        if (md_rsp.done) begin
          state_next = ST_LNI;
        end
      end
      ST_LNI, ST_LDI: begin
        md_req.start = !issued && ln_done && ld_done;
        md_req.steps = CNT_W'(32 - LOG_LB);
        md_req.a     = DIV_W'(tab_d);
        md_req.b     = DIV_W'(tab_w);
        if (md_rsp.done) begin
          state_next = (state == ST_LNI) ? ST_LDI : ST_IDF;
        end
      end
      ST_IDF: begin
        md_req.steps = CNT_W'(28);
        md_req.a     = DIV_W'(diff);
        md_req.b     = DIV_W'(LN2_Q28);
        if (md_rsp.done) begin
          state_next = ST_NRM;
        end
      end
      ST_NRM: begin
        md_req.steps = CNT_W'(9);
        md_req.a     = DIV_W'(ratio);
        md_req.b     = DIV_W'(bc);
        if (md_rsp.done) begin
          state_next = ST_DEN;
        end
      end
      ST_DEN: begin
        md_req.steps = CNT_W'(10);
        md_req.a     = DIV_W'(norm);
        md_req.b     = DIV_W'(sat_k);
        if (md_rsp.done) begin
          state_next = ST_NUM;
        end
      end
      ST_NUM: begin
        md_req.steps = CNT_W'(11);
        md_req.a     = DIV_W'(tf) << 8;
        md_req.b     = DIV_W'({1'b0, sat_k} + 11'd256);
        if (md_rsp.done) begin
          state_next = ST_FAC;
        end
      end
      ST_FAC: begin
        // quotient of (num << 24) / den fits 27 bits since den >= tf << 16
        md_req.is_div = 1'b1;
        md_req.steps  = CNT_W'(27);
        md_req.a      = DIV_W'(num >> 3);
        md_req.b      = DIV_W'(den);
        md_req.c      = {num[2:0], 61'd0};
        if (md_rsp.done) begin
          state_next = ST_TRM;
        end
      end
      ST_TRM: begin
        md_req.steps = CNT_W'(27);
        md_req.a     = DIV_W'(idf);
        md_req.b     = DIV_W'(factor);
        if (md_rsp.done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        md_req.start = 1'b0;
        if (!last_q || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        md_req.start = 1'b0;
        state_next   = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= 1'b0;
    end else if (md_rsp.done) begin
      issued <= 1'b0;
    end else if (md_req.start) begin
      issued <= 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_docs <= '0;
      avg_len    <= '0;
      sat_k      <= K_RESET;
      len_w      <= B_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TOTAL_DOCS: total_docs <= cfg_data[23:0];
        CFG_AVG_LEN:    avg_len    <= cfg_data[27:0];
        CFG_SAT_K:      sat_k      <= cfg_data[9:0];
        CFG_LEN_WEIGHT: len_w      <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // term datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      tf     <= s_axis_tdata[15:0];
      dfc    <= (s_axis_tdata[39:16] > total_docs) ? total_docs : s_axis_tdata[39:16];
      dl     <= s_axis_tdata[59:40];
      last_q <= s_axis_tlast;
    end
    if (state == ST_CHECK) begin
      term_q <= '0;
    end
    if (md_rsp.done) begin
      unique case (state)
        ST_RATIO: ratio  <= md_rsp.quo[43:0];
        ST_LNI:   ln_q   <= log_val;
        ST_LDI:   ld_q   <= log_val;
        ST_IDF:   idf    <= 33'(md_rsp.prod >> LOG_FRAC);
        ST_NRM:   norm   <= 45'(((DIV_W'(9'd256 - bc)) << 16) + md_rsp.prod >> 8);
        ST_DEN:   den    <= 48'((DIV_W'(tf) << 16) + (md_rsp.prod >> 8));
        ST_NUM:   num    <= 35'(md_rsp.prod);
        ST_FAC:   factor <= md_rsp.quo[26:0];
        ST_TRM:   term_q <= (term_w >= DIV_W'(SCORE_MAX)) ? SCORE_MAX : term_w[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  // running sum and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      score_sum <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      out_score <= '0;
      out_sat   <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_ACC) begin
        if (!last_q) begin
          score_sum <= hit ? SCORE_MAX : sum_w[SCORE_W-1:0];
          ovf       <= ovf | hit;
        end else if (out_free) begin
          out_valid <= 1'b1;
          out_score <= hit ? SCORE_MAX : sum_w[SCORE_W-1:0];
          out_sat   <= ovf | hit;
          score_sum <= '0;
          ovf       <= 1'b0;
        end
      end
    end
  end

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !issued)
    else $error("term taken while the arithmetic unit holds a job");

  a_done_needs_job: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> issued)
    else $error("arithmetic unit finished a job never issued");

  a_ovf_at_max: assert property (@(posedge clk) disable iff (rst)
    ovf |-> score_sum == SCORE_MAX)
    else $error("overflow flag set with the sum below its maximum");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && last_q && out_valid && !m_axis_tready) |=> state == ST_ACC)
    else $error("document score dropped while the output word was stalled");

endmodule

// ----- sim/tb_bm25_document_scorer.sv -----
// tb_bm25_document_scorer: self-checking bench for the bm25 document scorer
// needs bm25s_pkg and bm25_document_scorer; runs a directed table, then random
// documents, checking every score word against a bit-true predictor
`timescale 1ns / 100ps

module tb_bm25_document_scorer;
  import bm25s_pkg::*;

  localparam int  SETTLE     = 300;      // cycles for one term plus margin
  localparam longint LIMIT   = 3000000;
  localparam int  NUM_ITEMS  = 1600;

  typedef struct {
    logic [27:0] score;
    logic        sat;
  } score_word_t;

  typedef struct {
    bit          is_cfg;
    logic [7:0]  idx;
    logic [27:0] data;
    logic [15:0] tf;
    logic [23:0] df;
    logic [19:0] dl;
    bit          last;
    bit          typed;
    logic [27:0] score;
    bit          sat;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // term_frequency, document_frequency, document_length
  logic        s_axis_tlast = 1'b0; // last_term
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // score
  logic        m_axis_tuser;        // saturated

  bm25_document_scorer DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [63:0] frac_tab [0:256];
  logic [63:0] num_docs, avg_len, k1, b_w;
  logic [63:0] run_sum;
  bit          run_sat;
  score_word_t score_q[$];
  int          errors = 0;
  bit          quiet = 0;
  longint      cycles = 0;
  int          items = 0;

  function automatic logic [63:0] log2_fixed(logic [63:0] x);
    logic [63:0] e, f, pos, idx, w, lo, hi;
    e = 0;
    if (x == 0) return 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e > 32) e = 32;
    f   = (x << (32 - e)) & 64'hFFFF_FFFF;
    pos = f * 256;
    idx = pos >> 32;
    w   = pos & 64'hFFFF_FFFF;
    if (idx >= 256) idx = 255;
    lo = frac_tab[idx];
    hi = frac_tab[idx + 1];
    if (hi < lo) hi = lo;
    return (e << 28) + lo + (((hi - lo) * w) >> 32);
  endfunction

  function automatic logic [63:0] bm25_term(logic [63:0] tf, logic [63:0] df, logic [63:0] dl);
    logic [63:0] ln, ld, idf, b, ratio, norm, den, num, factor;
    if (df > num_docs) df = num_docs;
    if (tf == 0 || df == 0 || avg_len == 0) return 0;
    ln  = log2_fixed(2 * num_docs + 2);
    ld  = log2_fixed(2 * df + 1);
    idf = (ln > ld) ? (((ln - ld) * 64'd186065279) >> 28) : 0;
    b   = (b_w > 256) ? 64'd256 : b_w;
    ratio  = (dl << 24) / avg_len;
    norm   = (((256 - b) << 16) + b * ratio) >> 8;
    den    = (tf << 16) + ((k1 * norm) >> 8);
    num    = (tf * (k1 + 256)) << 8;
    factor = (num << 24) / den;
    return (idf * factor) >> (52 - SCORE_FRAC_BITS);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [27:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TOTAL_DOCS: num_docs = 64'(data & 28'hFFFFFF);
      CFG_AVG_LEN:    avg_len  = 64'(data);
      CFG_SAT_K:      k1       = 64'(data & 28'h3FF);
      CFG_LEN_WEIGHT: b_w      = 64'(data & 28'h1FF);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (score_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one term word; expected score is queued at the handshake of a document's last term
  task automatic send_term(logic [15:0] tf, logic [23:0] df, logic [19:0] dl, bit last,
                           bit typed = 0, logic [27:0] t_score = 0, bit t_sat = 0);
    logic [63:0] sum;
    score_word_t w;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, dl, df, tf};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items++;
    sum = run_sum + bm25_term(64'(tf), 64'(df), 64'(dl));
    if (sum >= 64'hFFFFFFF) begin
      sum = 64'hFFFFFFF;
      run_sat = 1;
    end
    run_sum = sum;
    if (last) begin
      w.score = typed ? t_score : run_sum[27:0];
      w.sat   = typed ? t_sat : run_sat;
      score_q.push_back(w);
      run_sum = 0;
      run_sat = 0;
    end
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // receiver with bursts of stall
  int stall = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (stall > 0) begin
      m_axis_tready <= 1'b0;
      stall <= stall - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (score_q.size() == 0) begin
        report("unexpected word", m_axis_tdata, 0);
      end else begin
        score_word_t w;
        w = score_q.pop_front();
        if (m_axis_tdata !== {4'b0, w.score}) report("score", m_axis_tdata, {4'b0, w.score});
        if (m_axis_tuser !== w.sat) report("saturated", 32'(m_axis_tuser), 32'(w.sat));
      end
    end
  end

  row_t dir_tab[$];

  function automatic row_t t_row(logic [15:0] tf, logic [23:0] df, logic [19:0] dl, bit last,
                                 bit typed = 0, logic [27:0] sc = 0, bit sat = 0);
    row_t r;
    r = '{0, 0, 0, tf, df, dl, last, typed, sc, sat};
    return r;
  endfunction

  function automatic row_t c_row(logic [7:0] idx, logic [27:0] data);
    row_t r;
    r = '{1, idx, data, 0, 0, 0, 0, 0, 0, 0};
    return r;
  endfunction

  function automatic logic [27:0] pick_avg();
    case ($urandom_range(0, 5))
      0: return 28'd1;
      1: return 28'hFFFFFFF;
      2: return 28'(($urandom_range(1, 4000)) << 8);
      default: return 28'($urandom_range(1, 28'hFFFFFFF));
    endcase
  endfunction

  initial begin
    logic [63:0] z;
    logic [63:0] r;
    int doc_len;
    bit heavy;
    logic [15:0] tf;
    logic [23:0] df;
    logic [19:0] dl;

    // log2(1 + i/256) in q28
    for (int i = 0; i < 256; i++) begin
      z = ((64'd256 + 64'(i)) << 30) / 256;
      r = 0;
      for (int s = 0; s < 28; s++) begin
        z = (z * z) >> 30;
        r = r << 1;
        if (z >= (64'd1 << 31)) begin
          z = z >> 1;
          r = r | 64'd1;
        end
      end
      frac_tab[i] = r;
    end
    frac_tab[256] = 64'd1 << 28;
    num_docs = 0; avg_len = 0; k1 = 64'(K_RESET); b_w = 64'(B_RESET);
    run_sum = 0; run_sat = 0;

    // reset state: n and average length zero, so every term adds nothing
    dir_tab.push_back(t_row(16'hFFFF, 24'hFFFFFF, 20'hFFFFF, 1, 1, 0, 0));
    dir_tab.push_back(t_row(16'd5, 24'd3, 20'd100, 0));
    dir_tab.push_back(t_row(16'd1, 24'd1, 20'd1, 1, 1, 0, 0));
    dir_tab.push_back(c_row(CFG_TOTAL_DOCS, 28'd1000));
    dir_tab.push_back(c_row(CFG_AVG_LEN, 28'd100 << 8));
    dir_tab.push_back(t_row(16'd0, 24'd10, 20'd100, 1, 1, 0, 0));      // zero tf
    dir_tab.push_back(t_row(16'd3, 24'd0, 20'd100, 1, 1, 0, 0));       // zero df
    dir_tab.push_back(t_row(16'd3, 24'd10, 20'd0, 1));                  // empty document
    dir_tab.push_back(t_row(16'd3, 24'hFFFFFF, 20'd100, 1));            // df clamped to n
    dir_tab.push_back(t_row(16'hFFFF, 24'd1, 20'hFFFFF, 1));
    dir_tab.push_back(t_row(16'd2, 24'd50, 20'd80, 0));
    dir_tab.push_back(t_row(16'd7, 24'd999, 20'd120, 0));
    dir_tab.push_back(t_row(16'd1, 24'd1000, 20'd100, 1));
    dir_tab.push_back(c_row(CFG_LEN_WEIGHT, 28'd511));                  // weight above one
    dir_tab.push_back(c_row(CFG_SAT_K, 28'd1023));
    dir_tab.push_back(t_row(16'd4, 24'd2, 20'd300, 1));
    dir_tab.push_back(c_row(CFG_LEN_WEIGHT, 28'd0));
    dir_tab.push_back(c_row(CFG_SAT_K, 28'd0));
    dir_tab.push_back(t_row(16'd4, 24'd2, 20'd300, 1));
    dir_tab.push_back(c_row(8'd200, 28'hFFFFFFF));                       // no such register
    dir_tab.push_back(c_row(CFG_TOTAL_DOCS, 28'hFFFFFF));
    dir_tab.push_back(c_row(CFG_AVG_LEN, 28'd1));
    dir_tab.push_back(t_row(16'hFFFF, 24'd1, 20'hFFFFF, 1));
    dir_tab.push_back(c_row(CFG_AVG_LEN, 28'd0));
    dir_tab.push_back(t_row(16'd9, 24'd9, 20'd9, 1, 1, 0, 0));          // zero average length

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        // drop the last term word so it is not taken a second time
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_term(dir_tab[i].tf, dir_tab[i].df, dir_tab[i].dl, dir_tab[i].last,
                  dir_tab[i].typed, dir_tab[i].score, dir_tab[i].sat);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (items < NUM_ITEMS) begin
      wait_idle();
      heavy = ($urandom_range(0, 3) == 0);
      if (heavy) begin
        // big idf and k1 so long documents saturate the sum
        write_reg(CFG_TOTAL_DOCS, 28'hFFFFFF);
        write_reg(CFG_SAT_K, 28'($urandom_range(800, 1023)));
        write_reg(CFG_LEN_WEIGHT, 28'($urandom_range(0, 256)));
        write_reg(CFG_AVG_LEN, 28'($urandom_range(1, 4000)) << 8);
      end else begin
        write_reg(CFG_TOTAL_DOCS, ($urandom_range(0, 9) == 0) ? 28'd0 :
                  ($urandom_range(0, 3) == 0) ? 28'hFFFFFF : 28'($urandom_range(1, 24'hFFFFFF)));
        write_reg(CFG_AVG_LEN, pick_avg());
        write_reg(CFG_SAT_K, ($urandom_range(0, 3) == 0) ? 28'd1023 : 28'($urandom_range(0, 1023)));
        write_reg(CFG_LEN_WEIGHT, 28'($urandom_range(0, 511)));
      end
      for (int d = 0; d < 12 && items < NUM_ITEMS; d++) begin
        doc_len = heavy && $urandom_range(0, 1) ? $urandom_range(50, 70) : $urandom_range(1, 8);
        if (items > NUM_ITEMS - 200) quiet = 1;
        for (int t = 0; t < doc_len; t++) begin
          if (heavy) begin
            tf = 16'($urandom_range(1000, 65535));
            df = 24'($urandom_range(0, 3));
          end else begin
            tf = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            df = ($urandom_range(0, 2) == 0) ? 24'($urandom) :
                 24'($urandom_range(0, 32'(num_docs + num_docs / 8 + 1)));
          end
          dl = ($urandom_range(0, 1) == 0) ? 20'($urandom) :
               20'((avg_len >> 8) + 64'($urandom_range(0, 64)));
          send_term(tf, df, dl, t == doc_len - 1);
        end
      end
      s_axis_tvalid <= 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
